// ===== design/assert_macros.svh =====
// assertion helpers for the framebuffer engine rtl
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== design/tfe_pkg.sv =====
package tfe_pkg;

    // panel geometry
    localparam int PANEL_WIDTH  = 152;
    localparam int PANEL_HEIGHT = 296;
    localparam int PLANE_BYTES  = 5624;
    localparam int ROW_BYTES    = PANEL_WIDTH / 8;
    localparam int ADDR_W       = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;

    // request codes
    localparam logic [1:0] REQ_DRAW = 2'd0;
    localparam logic [1:0] REQ_FILL = 2'd1;
    localparam logic [1:0] REQ_LOAD = 2'd2;
    localparam logic [1:0] REQ_READ = 2'd3;

    // colour codes, anything else acts as white
    localparam logic [1:0] COL_WHITE = 2'd0;
    localparam logic [1:0] COL_BLACK = 2'd1;
    localparam logic [1:0] COL_RED   = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [1:0]         color;
        logic [7:0]         pattern;
        logic [3:0]         bit_count;
        logic [12:0]        byte_index;
        logic               plane;
        logic [7:0]         data;
    } req_t;

    typedef struct packed {
        logic [7:0] black_byte;
        logic [7:0] red_byte;
    } rsp_t;

    // byte targets of one draw request, up to two bytes
    typedef struct packed {
        logic              hit0;
        logic [ADDR_W-1:0] addr0;
        logic [7:0]        mask0;
        logic              hit1;
        logic [ADDR_W-1:0] addr1;
        logic [7:0]        mask1;
    } geom_t;

endpackage

// ===== design/tfe_ram.sv =====
module tfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/tfe_geom.sv =====
module tfe_geom
    import tfe_pkg::*;
(
    input  req_t  req,
    output geom_t geom
);

    logic [7:0]         en;
    logic [15:0]        spread;
    logic signed [31:0] px;
    logic signed [31:0] row_base;
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic               row_ok;

    always_comb
    begin
        // per pixel enable, en[7] is the pixel at x
        en = 8'h00;
        px = 32'sd0;
        for (int i = 0; i < 8; i++)
        begin
            px = 32'(req.x) + 32'(i);
            en[7-i] = req.pattern[7-i] && (4'(i) < req.bit_count)
                      && (px >= 0) && (px < PANEL_WIDTH);
        end

        // split across the two bytes touched
        spread = {en, 8'h00} >> req.x[2:0];

        row_ok   = (req.y >= 0) && (32'(req.y) < PANEL_HEIGHT);
        row_base = 32'(req.y) * ROW_BYTES;
        a0       = row_base + 32'(req.x >>> 3);
        a1       = a0 + 32'sd1;

        geom.mask0 = spread[15:8];
        geom.mask1 = spread[7:0];
        geom.hit0  = row_ok && (spread[15:8] != 8'h00) && (a0 >= 0) && (a0 < PLANE_BYTES);
        geom.hit1  = row_ok && (spread[7:0] != 8'h00) && (a1 >= 0) && (a1 < PLANE_BYTES);
        geom.addr0 = a0[ADDR_W-1:0];
        geom.addr1 = a1[ADDR_W-1:0];
    end

endmodule

// ===== design/tfe_rmw.sv =====
module tfe_rmw
    import tfe_pkg::*;
(
    input  logic [7:0] old_black,
    input  logic [7:0] old_red,
    input  logic [7:0] mask,
    input  logic [1:0] color,
    output logic [7:0] new_black,
    output logic [7:0] new_red
);

    always_comb
    begin
        case (color)
            COL_BLACK:
            begin
                new_black = old_black & ~mask;
                new_red   = old_red | mask;
            end
            COL_RED:
            begin
                new_black = old_black | mask;
                new_red   = old_red & ~mask;
            end
            default:
            begin
                new_black = old_black | mask;
                new_red   = old_red | mask;
            end
        endcase
    end

endmodule

// ===== design/tricolor_framebuffer_engine.sv =====
// channel | signals                        | direction | transfer when
// --------+--------------------------------+-----------+----------------------
// request | req_valid, req_stall, req      | into core | req_valid && !req_stall
// result  | rsp_valid, rsp_stall, rsp      | out       | rsp_valid && !rsp_stall
//
// one request at a time, draws and sweeps share one read-modify-write unit
// draw: geometry, a read for each of two bytes, a write per touched byte
// load: one write, read: address then capture, fill: a whole-plane sweep (one byte per cycle)
// after reset both planes are swept to white with req_stall high
// a new request is taken while an earlier result still waits on rsp_stall
`include "assert_macros.svh"

module tricolor_framebuffer_engine
    import tfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // sequencer codes
    localparam logic [3:0] ST_SWEEP = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_PREP  = 4'd2;
    localparam logic [3:0] ST_RD0   = 4'd3;
    localparam logic [3:0] ST_WR0   = 4'd4;
    localparam logic [3:0] ST_RD1   = 4'd5;
    localparam logic [3:0] ST_WR1   = 4'd6;
    localparam logic [3:0] ST_LOAD  = 4'd7;
    localparam logic [3:0] ST_RDA   = 4'd8;
    localparam logic [3:0] ST_RDB   = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PLANE_BYTES - 1);

    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [1:0]        sweep_color_reg, sweep_color_next;
    logic              sweep_rsp_reg, sweep_rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;
    req_t              req_reg, req_next;
    geom_t             geom_reg, geom_next;
    rsp_t              res_reg, res_next;
    rsp_t              rsp_reg, rsp_next;

    geom_t             geom;
    logic              addr_ok;
    logic              out_free;

    // plane ports
    logic [ADDR_W-1:0] ram_addr;
    logic              we_black, we_red;
    logic [7:0]        wdata_black, wdata_red;
    logic [7:0]        rdata_black, rdata_red;

    // shared read-modify-write unit inputs and outputs
    logic [7:0]        rmw_mask;
    logic [1:0]        rmw_color;
    logic [7:0]        new_black, new_red;

    tfe_geom u_geom (
        .req  (req_reg),
        .geom (geom)
    );

    tfe_rmw u_rmw (
        .old_black (rdata_black),
        .old_red   (rdata_red),
        .mask      (rmw_mask),
        .color     (rmw_color),
        .new_black (new_black),
        .new_red   (new_red)
    );

    tfe_ram #(
        .WIDTH (8),
        .DEPTH (PLANE_BYTES)
    ) u_black_ram (
        .clk   (clk),
        .we    (we_black),
        .addr  (ram_addr),
        .wdata (wdata_black),
        .rdata (rdata_black)
    );

    tfe_ram #(
        .WIDTH (8),
        .DEPTH (PLANE_BYTES)
    ) u_red_ram (
        .clk   (clk),
        .we    (we_red),
        .addr  (ram_addr),
        .wdata (wdata_red),
        .rdata (rdata_red)
    );

    // load and read address range check
    assign addr_ok   = 32'(req_reg.byte_index) < 32'(PLANE_BYTES);
    // result slot can take a new result this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // rmw unit operand select: full mask for sweeps, pixel mask for draws
    always_comb
    begin
        case (state_reg)
            ST_WR0:  rmw_mask = geom_reg.mask0;
            ST_WR1:  rmw_mask = geom_reg.mask1;
            default: rmw_mask = 8'hFF;
        endcase
        rmw_color = (state_reg == ST_SWEEP) ? sweep_color_reg : req_reg.color;
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        sweep_color_next = sweep_color_reg;
        sweep_rsp_next   = sweep_rsp_reg;
        rsp_valid_next   = rsp_valid_reg;
        req_next         = req_reg;
        geom_next        = geom_reg;
        res_next         = res_reg;
        rsp_next         = rsp_reg;

        ram_addr    = geom_reg.addr0;
        we_black    = 1'b0;
        we_red      = 1'b0;
        wdata_black = new_black;
        wdata_red   = new_red;

        // result register drains on its transfer
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_SWEEP:
            begin
                // whole-plane write, one byte per cycle
                ram_addr = cnt_reg;
                we_black = 1'b1;
                we_red   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = sweep_rsp_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    res_next = '0;
                    case (req.req_type)
                        REQ_DRAW: state_next = ST_PREP;
                        REQ_FILL:
                        begin
                            sweep_color_next = req.color;
                            sweep_rsp_next   = 1'b1;
                            cnt_next         = '0;
                            state_next       = ST_SWEEP;
                        end
                        REQ_LOAD: state_next = ST_LOAD;
                        default:  state_next = ST_RDA;
                    endcase
                end
            end
            ST_PREP:
            begin
                geom_next  = geom;
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                ram_addr   = geom_reg.addr0;
                state_next = geom_reg.hit0 ? ST_WR0 : ST_RD1;
            end
            ST_WR0:
            begin
                ram_addr   = geom_reg.addr0;
                we_black   = 1'b1;
                we_red     = 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                ram_addr   = geom_reg.addr1;
                state_next = geom_reg.hit1 ? ST_WR1 : ST_DONE;
            end
            ST_WR1:
            begin
                ram_addr   = geom_reg.addr1;
                we_black   = 1'b1;
                we_red     = 1'b1;
                state_next = ST_DONE;
            end
            ST_LOAD:
            begin
                ram_addr    = req_reg.byte_index[ADDR_W-1:0];
                wdata_black = req_reg.data;
                wdata_red   = req_reg.data;
                we_black    = addr_ok && !req_reg.plane;
                we_red      = addr_ok && req_reg.plane;
                state_next  = ST_DONE;
            end
            ST_RDA:
            begin
                ram_addr   = req_reg.byte_index[ADDR_W-1:0];
                state_next = ST_RDB;
            end
            ST_RDB:
            begin
                if (addr_ok)
                begin
                    res_next.black_byte = rdata_black;
                    res_next.red_byte   = rdata_red;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            cnt_reg         <= '0;
            sweep_color_reg <= COL_WHITE;
            sweep_rsp_reg   <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            sweep_color_reg <= sweep_color_next;
            sweep_rsp_reg   <= sweep_rsp_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        geom_reg <= geom_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    // sweep counter never runs past the last plane byte
    `ASSERT_ALWAYS(a_sweep_in_range, (state_reg != ST_SWEEP) || (cnt_reg <= LAST_ADDR))
    // a draw write always touches at least one pixel, other states use the full mask
    `ASSERT_ALWAYS(a_draw_mask_set, rmw_mask != 8'h00)
    // a finished request lands in the result register and frees the core
    `ASSERT_NEXT(a_done_delivers, (state_reg == ST_DONE) && out_free, rsp_valid_reg && (state_reg == ST_IDLE))

endmodule

// ===== test/fb_checker.sv =====
`timescale 1ns / 1ps

module fb_checker
    import tfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending,
    output int   checked
);

    localparam int MAX_PRINTS = 40;

    // shadow copy of both planes
    logic [7:0] black_shadow [PLANE_BYTES];
    logic [7:0] red_shadow   [PLANE_BYTES];

    rsp_t readout_q [$];

    int n_fail    = 0;
    int n_checked = 0;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_fail < MAX_PRINTS)
            $display("[%0t] mismatch on result %0d: %s got %h expected %h",
                     $time, n_checked, what, got, want);
        n_fail++;
    endtask

    // updates the shadow planes and returns the readout the request should give
    task automatic apply_request(input req_t r, output rsp_t res);
        int n_bits;
        int px;
        int py;
        int idx;
        logic [7:0] bit_mask;
        res = '0;
        case (r.req_type)
            REQ_DRAW:
            begin
                n_bits = (r.bit_count > 4'd8) ? 8 : int'(r.bit_count);
                py = $signed(r.y);
                for (int i = 0; i < n_bits; i++)
                begin
                    px = $signed(r.x) + i;
                    if (r.pattern[7 - i] && px >= 0 && px < PANEL_WIDTH &&
                        py >= 0 && py < PANEL_HEIGHT)
                    begin
                        idx = px / 8 + py * ROW_BYTES;
                        bit_mask = 8'h80 >> (px % 8);
                        if (idx < PLANE_BYTES)
                        begin
                            case (r.color)
                                COL_BLACK:
                                begin
                                    black_shadow[idx] &= ~bit_mask;
                                    red_shadow[idx]   |= bit_mask;
                                end
                                COL_RED:
                                begin
                                    black_shadow[idx] |= bit_mask;
                                    red_shadow[idx]   &= ~bit_mask;
                                end
                                default:
                                begin
                                    black_shadow[idx] |= bit_mask;
                                    red_shadow[idx]   |= bit_mask;
                                end
                            endcase
                        end
                    end
                end
            end
            REQ_FILL:
            begin
                for (int k = 0; k < PLANE_BYTES; k++)
                begin
                    black_shadow[k] = (r.color == COL_BLACK) ? 8'h00 : 8'hFF;
                    red_shadow[k]   = (r.color == COL_RED) ? 8'h00 : 8'hFF;
                end
            end
            REQ_LOAD:
            begin
                if (r.byte_index < PLANE_BYTES)
                begin
                    if (r.plane)
                        red_shadow[r.byte_index] = r.data;
                    else
                        black_shadow[r.byte_index] = r.data;
                end
            end
            default:
            begin
                if (r.byte_index < PLANE_BYTES)
                begin
                    res.black_byte = black_shadow[r.byte_index];
                    res.red_byte   = red_shadow[r.byte_index];
                end
            end
        endcase
    endtask

    always @(posedge clk)
    begin : watch
        rsp_t want;
        rsp_t predicted;
        if (!rst_n)
        begin
            readout_q.delete();
            for (int k = 0; k < PLANE_BYTES; k++)
            begin
                black_shadow[k] = 8'hFF;
                red_shadow[k]   = 8'hFF;
            end
        end
        else
        begin
            // result side first: a result never belongs to a request taken at the same edge
            if (rsp_valid && !rsp_stall)
            begin
                if (readout_q.size() == 0)
                    report_mismatch("result with nothing outstanding", rsp, 0);
                else
                begin
                    want = readout_q.pop_front();
                    if (rsp.black_byte !== want.black_byte)
                        report_mismatch("black_byte", rsp.black_byte, want.black_byte);
                    if (rsp.red_byte !== want.red_byte)
                        report_mismatch("red_byte", rsp.red_byte, want.red_byte);
                end
                n_checked++;
            end
            if (req_valid && !req_stall)
            begin
                apply_request(req, predicted);
                readout_q.push_back(predicted);
            end
        end
        fail_count <= n_fail;
        pending    <= readout_q.size();
        checked    <= n_checked;
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tfe_pkg::*;

    // colour code 3 decodes as white
    localparam logic [1:0] COL_OTHER = 2'd3;

    localparam int RANDOM_ITEMS   = 1450;
    localparam int PRESSURE_AT    = 300;   // random item that starts the result hold-off
    localparam int PRESSURE_ITEMS = 60;    // back-to-back transfers offered during it
    localparam int DRAIN_AT       = 700;   // random item before which the sender drains
    localparam int LONG_HOLD      = 400;
    // a fill walks the whole plane and the reset sweep does too, so allow many times that
    localparam int WATCHDOG_LIMIT = 30000;
    localparam int DRAIN_CYCLES   = 20;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int fail_count;
    int pending;
    int checked;

    // handshake between the sender and the receiver for the long hold-off
    int hold_asked   = 0;
    int hold_started = 0;

    int sent_per_type [4] = '{default: 0};

    always #1 clk = ~clk;

    tricolor_framebuffer_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    fb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // ------------------------------------------------------------------
    // request construction
    // ------------------------------------------------------------------

    // every field random, so unused fields carry noise
    function automatic req_t noise_req();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(req_t)-1:0];
    endfunction

    function automatic req_t draw_req(input logic [1:0] col, input int px, input int py,
                                      input logic [7:0] pat, input logic [3:0] cnt);
        req_t r;
        r = noise_req();
        r.req_type  = REQ_DRAW;
        r.color     = col;
        r.x         = px[15:0];
        r.y         = py[15:0];
        r.pattern   = pat;
        r.bit_count = cnt;
        return r;
    endfunction

    // load and read requests, both addressed by byte_index
    function automatic req_t addr_req(input logic [1:0] kind, input int addr,
                                      input logic pl, input logic [7:0] dat);
        req_t r;
        r = noise_req();
        r.req_type   = kind;
        r.byte_index = addr[12:0];
        r.plane      = pl;
        r.data       = dat;
        return r;
    endfunction

    function automatic req_t fill_req(input logic [1:0] col);
        req_t r;
        r = noise_req();
        r.req_type = REQ_FILL;
        r.color    = col;
        return r;
    endfunction

    // random mix: draws and readback aimed at a few hot row bands so reads see
    // painted bytes, a slice of full-range coordinates and addresses, rare fills
    function automatic req_t random_req(input bit allow_fill);
        req_t r;
        int pick;
        int row;
        int val;
        r = noise_req();
        pick = $urandom_range(0, 999);
        case ($urandom_range(0, 2))
            0:       row = $urandom_range(0, 2);
            1:       row = $urandom_range(PANEL_HEIGHT / 2 - 2, PANEL_HEIGHT / 2 + 1);
            default: row = $urandom_range(PANEL_HEIGHT - 3, PANEL_HEIGHT - 1);
        endcase
        if (allow_fill && pick < 8)
            r.req_type = REQ_FILL;
        else if (pick < 500)
        begin
            r.req_type = REQ_DRAW;
            if ($urandom_range(0, 9) != 0)
            begin
                // columns straddle both panel edges
                val = $urandom_range(0, PANEL_WIDTH + 7);
                val = val - 8;
                r.x = val[15:0];
                if ($urandom_range(0, 15) == 0)
                    val = ($urandom_range(0, 1) == 0) ? -1 : PANEL_HEIGHT;
                else
                    val = row;
                r.y = val[15:0];
            end
            // mostly legal bit counts, the rest keep the noise (which may be zero or above eight)
            if ($urandom_range(0, 4) != 0)
            begin
                val = $urandom_range(1, 8);
                r.bit_count = val[3:0];
            end
        end
        else
        begin
            r.req_type = (pick < 680) ? REQ_LOAD : REQ_READ;
            if ($urandom_range(0, 9) != 0)
            begin
                val = row * ROW_BYTES + $urandom_range(0, ROW_BYTES - 1);
                r.byte_index = val[12:0];
            end
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones, none in burst stretches
    function automatic int pick_gap(input bit burst);
        int p;
        if (burst)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // sender side, called at a rising edge and returns at one
    // ------------------------------------------------------------------

    // offer one request and hold it until the transfer; valid stays high
    // unless a gap follows, so back-to-back items never toggle it
    task automatic send_item(input req_t r, input int gap);
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent_per_type[r.req_type]++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid and step one edge, so a later offer lands in another time step
    task automatic pause_sender();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        pause_sender();
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        bit burst;
        burst = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset contents, address extremes, clipping, bit count corners
        send_item(addr_req(REQ_READ, 0, 1'b0, 8'h00), 0);
        send_item(addr_req(REQ_READ, PLANE_BYTES - 1, 1'b1, 8'hFF), pick_gap(0));
        send_item(addr_req(REQ_READ, 8191, 1'b0, 8'h00), 0);
        send_item(draw_req(COL_BLACK, 0, 0, 8'hFF, 4'd8), 0);
        // bit count above eight, pattern straddles two bytes
        send_item(draw_req(COL_RED, 4, 0, 8'hAA, 4'd15), pick_gap(0));
        // bit count zero draws nothing
        send_item(draw_req(COL_BLACK, 2, 0, 8'hFF, 4'd0), 0);
        send_item(draw_req(COL_OTHER, 6, 0, 8'hC3, 4'd8), 0);
        send_item(addr_req(REQ_READ, 0, 1'b0, 8'h00), 0);
        send_item(addr_req(REQ_READ, 1, 1'b0, 8'h00), pick_gap(0));
        // clipping at the left edge, right edge, far off panel both ways and below
        send_item(draw_req(COL_BLACK, -4, 1, 8'hFF, 4'd8), 0);
        send_item(draw_req(COL_RED, PANEL_WIDTH - 4, PANEL_HEIGHT - 1, 8'hFF, 4'd8), 0);
        send_item(draw_req(COL_BLACK, -32768, 32767, 8'hFF, 4'd8), 0);
        send_item(draw_req(COL_RED, 32767, -32768, 8'hFF, 4'd8), 0);
        send_item(draw_req(COL_BLACK, 0, PANEL_HEIGHT, 8'hFF, 4'd8), pick_gap(0));
        send_item(addr_req(REQ_READ, ROW_BYTES, 1'b0, 8'h00), 0);
        send_item(addr_req(REQ_READ, PLANE_BYTES - 1, 1'b0, 8'h00), 0);
        // loads at the last byte, the first byte, and past the plane
        send_item(addr_req(REQ_LOAD, PLANE_BYTES - 1, 1'b0, 8'h5A), 0);
        send_item(addr_req(REQ_LOAD, 0, 1'b1, 8'hA5), 0);
        send_item(addr_req(REQ_LOAD, PLANE_BYTES, 1'b0, 8'h00), 0);
        send_item(addr_req(REQ_LOAD, 8191, 1'b1, 8'h00), pick_gap(0));
        send_item(addr_req(REQ_READ, PLANE_BYTES - 1, 1'b1, 8'hFF), 0);
        send_item(addr_req(REQ_READ, 0, 1'b1, 8'hFF), 0);
        // fills of each colour, with readback between them and a draw after the first
        send_item(fill_req(COL_BLACK), 0);
        send_item(draw_req(COL_WHITE, 8, 0, 8'hF0, 4'd4), 0);
        send_item(addr_req(REQ_READ, 1, 1'b0, 8'h00), 0);
        send_item(fill_req(COL_RED), 0);
        send_item(addr_req(REQ_READ, 100, 1'b0, 8'h00), 0);
        send_item(fill_req(COL_WHITE), pick_gap(0));

        // random part, stretches of 64 items switch between bursts and gaps
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
                burst = ($urandom_range(0, 2) == 0);
            if (n == PRESSURE_AT)
            begin
                // receiver holds off while requests keep coming, so the core backs up
                pause_sender();
                hold_asked++;
                while (hold_started < hold_asked)
                    @(posedge clk);
                for (int k = 0; k < PRESSURE_ITEMS; k++)
                    send_item(random_req(1'b0), 0);
            end
            if (n == DRAIN_AT)
                wait_drained();
            send_item(random_req(1'b1), pick_gap(burst));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d draws, %0d fills, %0d loads, %0d reads with %0d results checked",
                 sent_per_type[REQ_DRAW], sent_per_type[REQ_FILL],
                 sent_per_type[REQ_LOAD], sent_per_type[REQ_READ], checked);
        $display("random gaps and stalls on both channels, a %0d-cycle result hold-off, a drain",
                 LONG_HOLD);
        if (fail_count == 0)
            $display("PASS tricolor_framebuffer_engine");
        else
            $display("FAIL tricolor_framebuffer_engine");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver side: stall in segments of random length
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int len;
        int pick;
        @(posedge clk);
        forever
        begin
            if (hold_started < hold_asked)
            begin
                // long hold-off, counted here while the sender keeps offering
                hold_started++;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    rsp_stall <= 1'b0;
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 30);
                end
                else
                begin
                    rsp_stall <= 1'b1;
                    if (pick < 85)
                        len = $urandom_range(1, 3);
                    else if (pick < 97)
                        len = $urandom_range(4, 15);
                    else
                        len = $urandom_range(20, 100);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: cycles with no transfer on either channel
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
        $display("FAIL tricolor_framebuffer_engine");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/tfe_pkg.sv
design/tfe_ram.sv
design/tfe_geom.sv
design/tfe_rmw.sv
design/tricolor_framebuffer_engine.sv
test/fb_checker.sv
test/tb_top.sv
